// ===== hw/rtl/pcds_pkg.sv =====
// Shared constants, reciprocal table, state encoding and inter-module structs for the divider search.
package pcds_pkg;

  // Crystal reference and search limits.
  localparam int unsigned XTAL_HZ = 24000000;
  localparam logic [5:0] LOOP_MIN = 6'd27;
  localparam logic [5:0] LOOP_MAX = 6'd54;
  localparam logic [2:0] POST_LAST = 3'd4;
  localparam logic [2:0] DIV_LAST = 3'd7;
  localparam logic [31:0] ERR_INIT = 32'hFFFF_FFFF;

  // Width of a candidate clock: 24 MHz times 54 stays below 2^31.
  localparam int unsigned CLK_W = 31;

  localparam logic [63:0] TWO32 = 64'h1_0000_0000;

  // floor(2^32 / (pre * final)), indexed by {pre - 1, final - 1}.
  localparam logic [32:0] RECIP [64] = '{
    33'(TWO32 / 1),  33'(TWO32 / 2),  33'(TWO32 / 3),  33'(TWO32 / 4),
    33'(TWO32 / 5),  33'(TWO32 / 6),  33'(TWO32 / 7),  33'(TWO32 / 8),
    33'(TWO32 / 2),  33'(TWO32 / 4),  33'(TWO32 / 6),  33'(TWO32 / 8),
    33'(TWO32 / 10), 33'(TWO32 / 12), 33'(TWO32 / 14), 33'(TWO32 / 16),
    33'(TWO32 / 3),  33'(TWO32 / 6),  33'(TWO32 / 9),  33'(TWO32 / 12),
    33'(TWO32 / 15), 33'(TWO32 / 18), 33'(TWO32 / 21), 33'(TWO32 / 24),
    33'(TWO32 / 4),  33'(TWO32 / 8),  33'(TWO32 / 12), 33'(TWO32 / 16),
    33'(TWO32 / 20), 33'(TWO32 / 24), 33'(TWO32 / 28), 33'(TWO32 / 32),
    33'(TWO32 / 5),  33'(TWO32 / 10), 33'(TWO32 / 15), 33'(TWO32 / 20),
    33'(TWO32 / 25), 33'(TWO32 / 30), 33'(TWO32 / 35), 33'(TWO32 / 40),
    33'(TWO32 / 6),  33'(TWO32 / 12), 33'(TWO32 / 18), 33'(TWO32 / 24),
    33'(TWO32 / 30), 33'(TWO32 / 36), 33'(TWO32 / 42), 33'(TWO32 / 48),
    33'(TWO32 / 7),  33'(TWO32 / 14), 33'(TWO32 / 21), 33'(TWO32 / 28),
    33'(TWO32 / 35), 33'(TWO32 / 42), 33'(TWO32 / 49), 33'(TWO32 / 56),
    33'(TWO32 / 8),  33'(TWO32 / 16), 33'(TWO32 / 24), 33'(TWO32 / 32),
    33'(TWO32 / 40), 33'(TWO32 / 48), 33'(TWO32 / 56), 33'(TWO32 / 64)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HV,
    ST_TGT,
    ST_SEARCH,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // One divider combination as the sequencer walks it.
  typedef struct packed {
    logic [5:0] loop_div;
    logic [2:0] post_sel;
    logic [2:0] pre_m1;
    logic [2:0] fin_m1;
  } cand_tag_t;

  typedef struct packed {
    logic      valid;
    cand_tag_t tag;
  } cand_t;

  typedef struct packed {
    logic             valid;
    cand_tag_t        tag;
    logic [CLK_W-1:0] clk_hz;
  } clk_res_t;

  typedef struct packed {
    cand_tag_t   tag;
    logic [31:0] err;
  } best_t;

endpackage

// ===== hw/rtl/pcds_clk_unit.sv =====
// Pipelined candidate clock unit: 24 MHz times loop, shifted by post, divided by pre times final.
module pcds_clk_unit (
  input  logic             clk,
  input  logic             rst,
  input  pcds_pkg::cand_t  cand,
  output pcds_pkg::clk_res_t res,
  output logic             busy
);
  import pcds_pkg::*;

  logic [CLK_W-1:0] base;
  logic             s1_valid;
  cand_tag_t        s1_tag;
  logic [CLK_W-1:0] s1_num;
  logic [6:0]       s1_den;
  logic [32:0]      s1_recip;

  logic [63:0]      prod;
  logic             s2_valid;
  cand_tag_t        s2_tag;
  logic [CLK_W-1:0] s2_q0;
  logic [7:0]       s2_num_lo;
  logic [6:0]       s2_den;

  logic [7:0]       qd_lo;
  logic [7:0]       rem_lo;
  logic             corr;

  // Nested truncating divisions collapse into one floor by the product of divisors.
  assign base = CLK_W'(XTAL_HZ) * CLK_W'(cand.tag.loop_div);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cand.valid;
    end
    s1_tag   <= cand.tag;
    s1_num   <= base >> cand.tag.post_sel;
    s1_den   <= (7'(cand.tag.pre_m1) + 7'd1) * (7'(cand.tag.fin_m1) + 7'd1);
    s1_recip <= RECIP[{cand.tag.pre_m1, cand.tag.fin_m1}];
  end

  // The reciprocal estimate is the true quotient or one below it.
  assign prod = 64'(s1_num) * 64'(s1_recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_tag    <= s1_tag;
    s2_q0     <= prod[62:32];
    s2_num_lo <= s1_num[7:0];
    s2_den    <= s1_den;
  end

  // The remainder is below twice the divisor, so eight low bits give it exactly.
  assign qd_lo  = 8'(s2_q0[7:0] * 8'(s2_den));
  assign rem_lo = s2_num_lo - qd_lo;
  assign corr   = (rem_lo >= 8'(s2_den));

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= s2_valid;
    end
    res.tag    <= s2_tag;
    res.clk_hz <= s2_q0 + CLK_W'(corr);
  end

  assign busy = s1_valid | s2_valid | res.valid;

endmodule

// ===== hw/rtl/pcds_best.sv =====
// Error stage and running minimum over the candidate stream.
module pcds_best (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic [31:0]        target,
  input  pcds_pkg::clk_res_t res,
  output pcds_pkg::best_t    best,
  output logic               busy
);
  import pcds_pkg::*;

  logic [31:0] clk32;
  logic [31:0] diff;
  logic        e_valid;
  cand_tag_t   e_tag;
  logic [31:0] e_err;

  assign clk32 = 32'(res.clk_hz);
  assign diff  = (clk32 > target) ? (clk32 - target) : (target - clk32);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= res.valid;
    end
    e_tag <= res.tag;
    e_err <= diff;
  end

  // Only a strictly smaller error replaces the best, so the earliest combination wins ties.
  always_ff @(posedge clk) begin
    if (clear) begin
      best.err          <= ERR_INIT;
      best.tag.loop_div <= LOOP_MIN;
      best.tag.post_sel <= '0;
      best.tag.pre_m1   <= '0;
      best.tag.fin_m1   <= '0;
    end else if (e_valid && (e_err < best.err)) begin
      best.err <= e_err;
      best.tag <= e_tag;
    end
  end

  assign busy = e_valid;

endmodule

// ===== hw/rtl/pixel_clock_divider_search.sv =====
// Top level of the pixel clock divider search: sequencer, target product and result register.
//
//  Channel | Handshake            | Beat contents
//  --------+----------------------+------------------------------------------------------
//  in      | in_valid / in_ready  | active sizes, sync widths, porches, frames_per_second
//  out     | out_valid / out_ready| loop, post, pre and final dividers, clock_error
//
// After a beat on the input is accepted, the target is formed in ST_HV and ST_TGT
// (horizontal total times vertical total, then times the frame rate), ST_SEARCH issues
// every divider combination in turn into the shared five-stage divide and compare
// pipeline, and ST_DRAIN lets it empty before the result goes to the output register.
// The input is ready only while the sequencer is idle; a finished result may still sit
// unclaimed in the output register while the next beat is taken.
// If the previous result has not been taken when a search ends, the sequencer holds the
// new one in the running-best registers until the output register is free.
// Reset is synchronous and clears the sequencer and all valid flags.
module pixel_clock_divider_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] active_width,
  input  logic [10:0] active_height,
  input  logic [7:0]  hsync_width,
  input  logic [7:0]  h_front,
  input  logic [7:0]  h_back,
  input  logic [7:0]  vsync_width,
  input  logic [7:0]  v_front,
  input  logic [7:0]  v_back,
  input  logic [7:0]  frames_per_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  loop_divider,
  output logic [4:0]  post_divider,
  output logic [3:0]  pre_divider,
  output logic [3:0]  final_divider,
  output logic [31:0] clock_error
);
  import pcds_pkg::*;

  state_t      state;
  state_t      state_next;

  // Timing totals; each fits in twelve bits even with every porch at its maximum.
  logic [11:0] htot;
  logic [11:0] vtot;
  logic [7:0]  fps;
  logic [23:0] hv;
  logic [31:0] target;

  // Search counters, walked in the order loop, post, pre, final.
  logic [5:0]  loop_cnt;
  logic [2:0]  post_cnt;
  logic [2:0]  pre_cnt;
  logic [2:0]  fin_cnt;
  logic        search_last;

  cand_t       cand;
  clk_res_t    cu_res;
  logic        cu_busy;
  best_t       best;
  logic        bu_busy;
  logic        best_clear;
  logic        load_out;

  assign search_last = (loop_cnt == LOOP_MAX) && (post_cnt == POST_LAST) &&
                       (pre_cnt == DIV_LAST) && (fin_cnt == DIV_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cand.valid   = 1'b0;
    cand.tag     = '{loop_div: loop_cnt, post_sel: post_cnt, pre_m1: pre_cnt, fin_m1: fin_cnt};
    best_clear   = 1'b0;
    load_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_HV;
        end
      end
      ST_HV: begin
        state_next = ST_TGT;
      end
      ST_TGT: begin
        best_clear = 1'b1;
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        cand.valid = 1'b1;
        if (search_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!cu_busy && !bu_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Target: the totals are summed as the beat is taken, then two registered multiplies.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      htot <= 12'(active_width) + 12'(hsync_width) + 12'(h_front) + 12'(h_back);
      vtot <= 12'(active_height) + 12'(vsync_width) + 12'(v_front) + 12'(v_back);
      fps  <= frames_per_second;
    end
    if (state == ST_HV) begin
      hv <= 24'(htot) * 24'(vtot);
    end
    if (state == ST_TGT) begin
      target <= 32'(hv) * 32'(fps);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_cnt <= LOOP_MIN;
      post_cnt <= '0;
      pre_cnt  <= '0;
      fin_cnt  <= '0;
    end else if (state == ST_TGT) begin
      loop_cnt <= LOOP_MIN;
      post_cnt <= '0;
      pre_cnt  <= '0;
      fin_cnt  <= '0;
    end else if (state == ST_SEARCH) begin
      fin_cnt <= fin_cnt + 3'd1;
      if (fin_cnt == DIV_LAST) begin
        pre_cnt <= pre_cnt + 3'd1;
        if (pre_cnt == DIV_LAST) begin
          if (post_cnt == POST_LAST) begin
            post_cnt <= '0;
            loop_cnt <= loop_cnt + 6'd1;
          end else begin
            post_cnt <= post_cnt + 3'd1;
          end
        end
      end
    end
  end

  pcds_clk_unit u_clk_unit (
    .clk  (clk),
    .rst  (rst),
    .cand (cand),
    .res  (cu_res),
    .busy (cu_busy)
  );

  pcds_best u_best (
    .clk    (clk),
    .rst    (rst),
    .clear  (best_clear),
    .target (target),
    .res    (cu_res),
    .best   (best),
    .busy   (bu_busy)
  );

  // Output register: holds a result until it is taken, independent of the search.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      loop_divider  <= best.tag.loop_div;
      post_divider  <= 5'd1 << best.tag.post_sel;
      pre_divider   <= 4'(best.tag.pre_m1) + 4'd1;
      final_divider <= 4'(best.tag.fin_m1) + 4'd1;
      clock_error   <= best.err;
    end
  end

endmodule

// ===== hw/rtl/pcds_checker.sv =====
// Port-level checker for the divider search, bound to the top level.
module pcds_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  loop_divider,
  input logic [4:0]  post_divider,
  input logic [3:0]  pre_divider,
  input logic [3:0]  final_divider,
  input logic [31:0] clock_error
);
  import pcds_pkg::*;

  // The sequencer leaves idle as soon as a beat is taken, so the input closes straight after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready again straight after a beat was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(loop_divider) &&
    $stable(post_divider) && $stable(pre_divider) && $stable(final_divider) &&
    $stable(clock_error))
    else $error("stalled result changed or was dropped");

  a_loop_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> loop_divider >= LOOP_MIN && loop_divider <= LOOP_MAX)
    else $error("loop divider outside its range");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(post_divider) && pre_divider != 4'd0 && pre_divider <= 4'd8 &&
    final_divider != 4'd0 && final_divider <= 4'd8)
    else $error("post, pre or final divider outside its set");

endmodule

bind pixel_clock_divider_search pcds_checker u_pcds_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .loop_divider  (loop_divider),
  .post_divider  (post_divider),
  .pre_divider   (pre_divider),
  .final_divider (final_divider),
  .clock_error   (clock_error)
);

// ===== dv/pixel_clock_divider_search_tb.sv =====
// Self-checking testbench for the pixel clock divider search, with its own divider predictor.
module pixel_clock_divider_search_tb;
  import pcds_pkg::*;

  // One display timing request, as offered on the input channel.
  typedef struct packed {
    logic [10:0] active_width;
    logic [10:0] active_height;
    logic [7:0]  hsync_width;
    logic [7:0]  h_front;
    logic [7:0]  h_back;
    logic [7:0]  vsync_width;
    logic [7:0]  v_front;
    logic [7:0]  v_back;
    logic [7:0]  frames_per_second;
  } timing_t;

  // One chosen divider setting, as returned on the output channel.
  typedef struct packed {
    logic [5:0]  loop_divider;
    logic [4:0]  post_divider;
    logic [3:0]  pre_divider;
    logic [3:0]  final_divider;
    logic [31:0] clock_error;
  } divider_setting_t;

  // Idling regimes, stepped through as input beats are taken.
  typedef enum logic [1:0] {
    PHASE_SLOW_SINK,
    PHASE_SLOW_SOURCE,
    PHASE_FULL_RATE
  } load_phase_t;

  localparam int RANDOM_REQUESTS   = 100;
  localparam int PHASE_ONE_BEATS   = 38;
  localparam int PHASE_TWO_BEATS   = 76;
  localparam int SPARSE_IDLE_PCT   = 26;
  localparam int DENSE_IDLE_PCT    = 74;
  // The receiver holds off once, late in the full-rate phase, for long enough that
  // two searches complete behind it and the input channel has to stall.
  localparam int HOLD_AFTER_RESULTS = 85;
  localparam int HOLD_CYCLES        = 30000;
  // A search plus the long hold-off and the receiver's random stalls stays far below
  // this many cycles without any beat on either channel in a correct run.
  localparam int WATCHDOG_LIMIT     = 100000;
  // Quiet time at the end, a little over one search, so that a stray result shows.
  localparam int TAIL_CYCLES        = 9100;
  localparam int MAX_REPORTS        = 10;
  localparam int NUM_POST           = 5;
  localparam int MAX_DIV            = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic    in_valid = 1'b0;
  logic    in_ready;
  timing_t offer    = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  loop_divider;
  logic [4:0]  post_divider;
  logic [3:0]  pre_divider;
  logic [3:0]  final_divider;
  logic [31:0] clock_error;

  timing_t          timing_requests[$];
  divider_setting_t expected_settings[$];

  int in_beats      = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int stray_results = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;

  load_phase_t phase;

  pixel_clock_divider_search uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .active_width      (offer.active_width),
    .active_height     (offer.active_height),
    .hsync_width       (offer.hsync_width),
    .h_front           (offer.h_front),
    .h_back            (offer.h_back),
    .vsync_width       (offer.vsync_width),
    .v_front           (offer.v_front),
    .v_back            (offer.v_back),
    .frames_per_second (offer.frames_per_second),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .loop_divider      (loop_divider),
    .post_divider      (post_divider),
    .pre_divider       (pre_divider),
    .final_divider     (final_divider),
    .clock_error       (clock_error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The idling regime follows the number of input beats taken so far.
  always_comb begin
    if (in_beats < PHASE_ONE_BEATS) begin
      phase = PHASE_SLOW_SINK;
    end else if (in_beats < PHASE_TWO_BEATS) begin
      phase = PHASE_SLOW_SOURCE;
    end else begin
      phase = PHASE_FULL_RATE;
    end
  end

  // Works out the divider setting the block should pick. The target is the product
  // of the two totals and the frame rate, which always fits 32 bits. Every
  // combination is visited in the block's nesting order, and a candidate replaces
  // the best only when its error is strictly smaller, so on a tie the earliest one
  // stands. The post divider is a power of two, so its division is a plain shift.
  function automatic divider_setting_t best_divider_setting(timing_t t);
    logic [63:0]      product;
    logic [31:0]      htot;
    logic [31:0]      vtot;
    logic [31:0]      target;
    logic [31:0]      cand_hz;
    logic [31:0]      err;
    divider_setting_t best;
    htot = 32'(t.active_width) + 32'(t.hsync_width) + 32'(t.h_front) + 32'(t.h_back);
    vtot = 32'(t.active_height) + 32'(t.vsync_width) + 32'(t.v_front) + 32'(t.v_back);
    product = 64'(htot) * 64'(vtot) * 64'(t.frames_per_second);
    target = product[31:0];
    best.loop_divider  = LOOP_MIN;
    best.post_divider  = 5'd1;
    best.pre_divider   = 4'd1;
    best.final_divider = 4'd1;
    best.clock_error   = ERR_INIT;
    for (int lp = int'(LOOP_MIN); lp <= int'(LOOP_MAX); lp++) begin
      for (int ps = 0; ps < NUM_POST; ps++) begin
        for (int pr = 1; pr <= MAX_DIV; pr++) begin
          for (int fn = 1; fn <= MAX_DIV; fn++) begin
            cand_hz = ((XTAL_HZ * 32'(lp)) >> ps) / 32'(pr) / 32'(fn);
            err = (cand_hz > target) ? cand_hz - target : target - cand_hz;
            if (err < best.clock_error) begin
              best.loop_divider  = 6'(lp);
              best.post_divider  = 5'(1 << ps);
              best.pre_divider   = 4'(pr);
              best.final_divider = 4'(fn);
              best.clock_error   = err;
            end
          end
        end
      end
    end
    return best;
  endfunction

  function automatic timing_t make_timing(int aw, int ah, int hs, int hf, int hb,
                                          int vs, int vf, int vb, int fps);
    timing_t t;
    t.active_width      = 11'(aw);
    t.active_height     = 11'(ah);
    t.hsync_width       = 8'(hs);
    t.h_front           = 8'(hf);
    t.h_back            = 8'(hb);
    t.vsync_width       = 8'(vs);
    t.v_front           = 8'(vf);
    t.v_back            = 8'(vb);
    t.frames_per_second = 8'(fps);
    return t;
  endfunction

  // A third of the random requests are tiny frames, whose targets fall below the
  // slowest candidate clock or among the deepest divisions; the rest span every
  // field in full, which also gives each bit of each field both values.
  function automatic timing_t random_timing();
    timing_t t;
    if ($urandom_range(2) == 0) begin
      t = make_timing($urandom_range(63), $urandom_range(63), $urandom_range(15),
                      $urandom_range(15), $urandom_range(15), $urandom_range(15),
                      $urandom_range(15), $urandom_range(15), $urandom_range(255));
    end else begin
      t = make_timing($urandom_range(2047), $urandom_range(2047), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255));
    end
    return t;
  endfunction

  // Driver. A fresh beat is put up only once the previous one has been taken, and
  // the sender idles only between beats, so valid is never lowered while waiting.
  always @(posedge clk) begin
    bit send_idles;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_settings.push_back(best_divider_setting(offer));
        in_beats <= in_beats + 1;
      end
      case (phase)
        PHASE_SLOW_SINK:   send_idles = ($urandom_range(99) < SPARSE_IDLE_PCT);
        PHASE_SLOW_SOURCE: send_idles = ($urandom_range(99) < DENSE_IDLE_PCT);
        default:           send_idles = 1'b0;
      endcase
      if (timing_requests.size() != 0 && !send_idles) begin
        offer    <= timing_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor. Each result beat is matched against the oldest expected setting.
  always @(posedge clk) begin
    divider_setting_t want;
    bit               recv_idles;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_settings.size() == 0) begin
          stray_results <= stray_results + 1;
          $display("Stray result: loop %0d post %0d pre %0d final %0d err %0d",
                   loop_divider, post_divider, pre_divider, final_divider, clock_error);
        end else begin
          want = expected_settings.pop_front();
          if (loop_divider  !== want.loop_divider  || post_divider  !== want.post_divider ||
              pre_divider   !== want.pre_divider   || final_divider !== want.final_divider ||
              clock_error   !== want.clock_error) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_REPORTS) begin
              $display("Mismatch %0d: expected loop %0d post %0d pre %0d final %0d err %0d",
                       results_seen, want.loop_divider, want.post_divider,
                       want.pre_divider, want.final_divider, want.clock_error);
              $display("  got loop %0d post %0d pre %0d final %0d err %0d",
                       loop_divider, post_divider, pre_divider, final_divider,
                       clock_error);
            end
          end
        end
      end
      case (phase)
        PHASE_SLOW_SINK:   recv_idles = ($urandom_range(99) < DENSE_IDLE_PCT);
        PHASE_SLOW_SOURCE: recv_idles = ($urandom_range(99) < SPARSE_IDLE_PCT);
        default:           recv_idles = 1'b0;
      endcase
      out_ready <= (hold_left == 0) && !recv_idles;
    end
  end

  // The long hold-off on the output, counted down here while the driver keeps
  // offering requests, so that the block fills up and has to refuse its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen == HOLD_AFTER_RESULTS) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Smallest legal request: one pixel, one line, no blanking, one frame a second.
    timing_requests.push_back(make_timing(1, 1, 0, 0, 0, 0, 0, 0, 1));
    // Everything at zero, so the target itself is zero.
    timing_requests.push_back(make_timing(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Every field at its top value: the target lies above the fastest candidate.
    timing_requests.push_back(make_timing(2047, 2047, 255, 255, 255, 255, 255, 255, 255));
    // Zero active width, then zero active height, then zero frame rate, alone.
    timing_requests.push_back(make_timing(0, 1080, 44, 88, 148, 5, 4, 36, 60));
    timing_requests.push_back(make_timing(1920, 0, 44, 88, 148, 5, 4, 36, 60));
    timing_requests.push_back(make_timing(1920, 1080, 44, 88, 148, 5, 4, 36, 0));
    // A target of exactly 648 MHz, hit with no error by the very first combination.
    timing_requests.push_back(make_timing(2000, 1350, 0, 0, 0, 0, 0, 0, 240));
    // Familiar video modes.
    timing_requests.push_back(make_timing(640, 480, 96, 16, 48, 2, 10, 33, 60));
    timing_requests.push_back(make_timing(1280, 720, 40, 110, 220, 5, 5, 20, 60));
    timing_requests.push_back(make_timing(1920, 1080, 44, 88, 148, 5, 4, 36, 60));
    // Blanking only, with one-pixel active areas, and a wide single line.
    timing_requests.push_back(make_timing(1, 1, 255, 255, 255, 255, 255, 255, 255));
    timing_requests.push_back(make_timing(2047, 1, 0, 0, 0, 0, 0, 0, 1));
    // Alternating bit patterns, each bit of each field taking both values.
    timing_requests.push_back(make_timing(11'h555, 11'h2AA, 8'hAA, 8'h55, 8'hAA,
                                          8'h55, 8'hAA, 8'h55, 8'hAA));
    timing_requests.push_back(make_timing(11'h2AA, 11'h555, 8'h55, 8'hAA, 8'h55,
                                          8'hAA, 8'h55, 8'hAA, 8'h55));
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      timing_requests.push_back(random_timing());
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken, then for every result to come back.
    while (timing_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_settings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && stray_results == 0 && expected_settings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pcds_pkg.sv
hw/rtl/pcds_clk_unit.sv
hw/rtl/pcds_best.sv
hw/rtl/pixel_clock_divider_search.sv
hw/rtl/pcds_checker.sv
dv/pixel_clock_divider_search_tb.sv
